@@ sv/vlan_tag_edit_stream_defines.svh @@
// Assertion helpers for the VLAN tag edit stream.
`ifndef VLAN_TAG_EDIT_STREAM_DEFINES_SVH
`define VLAN_TAG_EDIT_STREAM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vte_pkg.sv @@
`default_nettype none

package vte_pkg;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_TAG   = 2'd2,
        MODE_STRIP = 2'd3
    } mode_t;

    // Register indexes (word address bits).
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_VLAN  = 2'd1;
    localparam logic [1:0] REG_PRIO  = 2'd2;

    // Header byte positions.
    localparam int         POS_W       = 5;
    localparam logic [4:0] POS_TYPE_HI = 5'd12;
    localparam logic [4:0] POS_TYPE_LO = 5'd13;
    localparam logic [4:0] POS_TCI_HI  = 5'd14;
    localparam logic [4:0] POS_TCI_LO  = 5'd15;
    localparam logic [4:0] POS_SAT     = 5'd16;

    // 802.1Q tag type bytes.
    localparam logic [7:0] TPID_HI = 8'h81;
    localparam logic [7:0] TPID_LO = 8'h00;

    // Most beats one input beat can produce, and its count width.
    localparam int RES_MAX = 6;
    localparam int CNT_W   = 3;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] vlan_value;
        logic [2:0]  priority_cfg;
    } cfg_t;

    typedef struct packed {
        logic [15:0] mark;
        logic        last;
        logic        first;
        logic [7:0]  data;
    } beat_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } res_t;

    // All output beats caused by one input beat.
    typedef struct packed {
        res_t [RES_MAX-1:0] ent;
        logic [CNT_W-1:0]   cnt;
        logic [15:0]        mark;
        logic               use_rule;
    } step_t;

    typedef struct packed {
        logic ready;
        logic final_beat;
    } burst_stat_t;

endpackage

`default_nettype wire

@@ sv/vte_core.sv @@
`default_nettype none

module vte_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire vte_pkg::cfg_t  cfg,
    input  wire vte_pkg::beat_t beat,
    input  wire logic           fire,
    output vte_pkg::step_t      step
);
    import vte_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       held_reg, held_next;
    logic             tagged_reg, tagged_next;
    logic [15:0]      mark_reg, mark_next;
    logic [7:0]       tci_hi_reg, tci_hi_next;

    function automatic res_t mk(input logic [7:0] d, input logic l);
        res_t r;
        r.data = d;
        r.last = l;
        return r;
    endfunction

    // Work out the output beats and the next frame state for one beat.
    always_comb begin
        logic             start;
        logic [POS_W-1:0] pos0;
        logic [15:0]      mark0;
        logic [15:0]      m;
        logic [15:0]      tci;
        logic             tag;
        logic             tagged0;
        logic             ins;
        logic [7:0]       d;
        logic             l;

        d       = beat.data;
        l       = beat.last;
        start   = beat.first || (pos_reg == '0);
        pos0    = start ? '0 : pos_reg;
        mark0   = start ? beat.mark : mark_reg;
        tagged0 = start ? 1'b0 : tagged_reg;
        ins     = (cfg.mode == MODE_TAG) && (mark0 != 16'd0);
        tci     = {tci_hi_reg, d};
        tag     = (held_reg == TPID_HI) && (d == TPID_LO);
        m       = mark0;

        held_next   = held_reg;
        tagged_next = tagged0;
        tci_hi_next = tci_hi_reg;
        step.ent    = '0;
        step.cnt    = '0;

        if (pos0 < POS_TYPE_HI) begin
            step.ent[0] = mk(d, l);
            step.cnt    = CNT_W'(1);
        end else if (pos0 == POS_TYPE_HI) begin
            // hold byte 12 until the type field is known
            held_next = d;
            if (l) begin
                step.ent[0] = mk(d, 1'b1);
                step.cnt    = CNT_W'(1);
            end
        end else if (pos0 == POS_TYPE_LO) begin
            tagged_next = tag;
            if (cfg.mode == MODE_SET && !tag
                && !(cfg.vlan_value == 16'd0 && mark0 == 16'd0)) begin
                if (cfg.vlan_value != 16'd0) m = cfg.vlan_value;
                if (cfg.priority_cfg != 3'd0) m = {cfg.priority_cfg, m[12:0]};
            end
            if (ins && !tag) begin
                // insert tag ahead of the type field
                step.ent[0] = mk(TPID_HI, 1'b0);
                step.ent[1] = mk(TPID_LO, 1'b0);
                step.ent[2] = mk(m[15:8], 1'b0);
                step.ent[3] = mk(m[7:0], 1'b0);
                step.ent[4] = mk(held_reg, 1'b0);
                step.ent[5] = mk(d, l);
                step.cnt    = CNT_W'(6);
            end else if (cfg.mode == MODE_STRIP && tag) begin
                if (l) begin
                    step.ent[0] = mk(TPID_HI, 1'b0);
                    step.ent[1] = mk(TPID_LO, 1'b1);
                    step.cnt    = CNT_W'(2);
                end
            end else begin
                step.ent[0] = mk(held_reg, 1'b0);
                step.ent[1] = mk(d, l);
                step.cnt    = CNT_W'(2);
            end
        end else if (pos0 == POS_TCI_HI) begin
            tci_hi_next = d;
            if (tagged0 && cfg.mode == MODE_STRIP) begin
                if (l) begin
                    step.ent[0] = mk(TPID_HI, 1'b0);
                    step.ent[1] = mk(TPID_LO, 1'b0);
                    step.ent[2] = mk(d, 1'b1);
                    step.cnt    = CNT_W'(3);
                end
            end else if (tagged0 && ins) begin
                if (l) begin
                    step.ent[0] = mk(d, 1'b1);
                    step.cnt    = CNT_W'(1);
                end
            end else begin
                step.ent[0] = mk(d, l);
                step.cnt    = CNT_W'(1);
            end
        end else if (pos0 == POS_TCI_LO) begin
            if (tagged0 && cfg.mode == MODE_SET) begin
                // rebuild the mark from the rule and the frame's TCI
                m = (cfg.vlan_value != 16'd0) ? cfg.vlan_value : {3'd0, tci[12:0]};
                if (cfg.priority_cfg == 3'd0) m = m | {tci[15:13], 13'd0};
                else m = {cfg.priority_cfg, m[12:0]};
                step.ent[0] = mk(d, l);
                step.cnt    = CNT_W'(1);
            end else if (tagged0 && ins) begin
                // overwrite the TCI with the mark
                step.ent[0] = mk(m[15:8], 1'b0);
                step.ent[1] = mk(m[7:0], l);
                step.cnt    = CNT_W'(2);
            end else if (tagged0 && cfg.mode == MODE_STRIP) begin
                if (l) begin
                    step.ent[0] = mk(TPID_HI, 1'b0);
                    step.ent[1] = mk(TPID_LO, 1'b0);
                    step.ent[2] = mk(tci_hi_reg, 1'b0);
                    step.ent[3] = mk(d, 1'b1);
                    step.cnt    = CNT_W'(4);
                end
            end else begin
                step.ent[0] = mk(d, l);
                step.cnt    = CNT_W'(1);
            end
        end else begin
            step.ent[0] = mk(d, l);
            step.cnt    = CNT_W'(1);
        end

        mark_next     = m;
        step.mark     = m;
        step.use_rule = !((cfg.mode == MODE_TAG) && (m == 16'd0));

        // advance the position, saturating past the header
        if (l) pos_next = '0;
        else if (pos0 < POS_SAT) pos_next = pos0 + POS_W'(1);
        else pos_next = pos0;
    end

    // Hold frame state; advance only when a beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            held_reg   <= '0;
            tagged_reg <= 1'b0;
            mark_reg   <= '0;
            tci_hi_reg <= '0;
        end else if (fire) begin
            pos_reg    <= pos_next;
            held_reg   <= held_next;
            tagged_reg <= tagged_next;
            mark_reg   <= mark_next;
            tci_hi_reg <= tci_hi_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/vte_burst.sv @@
`default_nettype none

module vte_burst (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire vte_pkg::step_t step,
    output vte_pkg::burst_stat_t stat,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,   // data_out[7:0], mark_out[23:8]
    output logic                m_tlast,
    output logic                m_tuser    // use_rule_target
);
    import vte_pkg::*;

    res_t [RES_MAX-1:0] ent_reg;
    logic [15:0]        mark_reg;
    logic               rule_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   rem_reg;

    // Take a new burst once the current one is gone or leaving now.
    assign stat.ready      = (rem_reg == '0) || ((rem_reg == CNT_W'(1)) && m_tready);
    assign stat.final_beat = (rem_reg == CNT_W'(1));

    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = {mark_reg, ent_reg[idx_reg].data};
    assign m_tlast  = ent_reg[idx_reg].last;
    assign m_tuser  = rule_reg;

    // Hold burst payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg  <= step.ent;
            mark_reg <= step.mark;
            rule_reg <= step.use_rule;
        end
    end

    // Advance through the burst one beat per handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            rem_reg <= '0;
        end else if (load) begin
            idx_reg <= '0;
            rem_reg <= step.cnt;
        end else if (m_tvalid && m_tready) begin
            idx_reg <= idx_reg + CNT_W'(1);
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ sv/vlan_tag_edit_stream.sv @@
// VLAN tag edit stream: takes an Ethernet frame one byte per beat with a
// 16-bit VLAN mark on the first beat, and inserts, rewrites or strips an
// 802.1Q tag or updates the mark as the mode register says. Each input beat
// passes an input register and then yields a burst of zero to six output
// beats from a small result buffer. Input is taken every cycle while each
// beat yields one output beat and m_tready is high; a beat that yields more
// output beats holds the input until its burst is on its final beat.
// Registers: mode at 0x0, vlan_value at 0x4, priority_cfg at 0x8; write
// them only while no frame is in flight.
`default_nettype none

`include "vlan_tag_edit_stream_defines.svh"

module vlan_tag_edit_stream (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input frame
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data[7:0], mark_in[23:8]
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // first
    // output frame
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // data_out[7:0], mark_out[23:8]
    output logic             m_tlast,
    output logic             m_tuser,   // use_rule_target
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vte_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    beat_t       in_beat_reg;
    logic        fire;
    step_t       step;
    burst_stat_t bstat;
    logic        wr_en;

    // Register port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= MODE_NONE;
            cfg_reg.vlan_value   <= '0;
            cfg_reg.priority_cfg <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MODE: cfg_reg.mode         <= mode_t'(pwdata[1:0]);
                REG_VLAN: cfg_reg.vlan_value   <= pwdata[15:0];
                REG_PRIO: cfg_reg.priority_cfg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE: prdata = {30'd0, cfg_reg.mode};
            REG_VLAN: prdata = {16'd0, cfg_reg.vlan_value};
            REG_PRIO: prdata = {29'd0, cfg_reg.priority_cfg};
            default:  prdata = '0;
        endcase
    end

    // Input register: hold one beat while the result buffer is busy.
    assign fire     = in_valid_reg && bstat.ready;
    assign s_tready = !in_valid_reg || bstat.ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_beat_reg.data  <= s_tdata[7:0];
            in_beat_reg.mark  <= s_tdata[23:8];
            in_beat_reg.first <= s_tuser;
            in_beat_reg.last  <= s_tlast;
        end
    end

    vte_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .beat    (in_beat_reg),
        .fire    (fire),
        .step    (step)
    );

    vte_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .step     (step),
        .stat     (bstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Forced accept only comes from tag mode with a zero mark.
    `VTE_ASSERT_IMP(a_forced_accept, m_tvalid && !m_tuser, cfg_reg.mode == MODE_TAG && m_tdata[23:8] == 16'd0, "forced accept outside tag mode")
    // The frame's final byte always closes its burst.
    `VTE_ASSERT_IMP(a_last_ends_burst, m_tvalid && m_tlast, bstat.final_beat, "last byte not at end of burst")
    // A pending input beat survives an output stall.
    `VTE_ASSERT_NXT(a_hold_pending, in_valid_reg && m_tvalid && !m_tready, in_valid_reg, "pending beat lost during stall")

endmodule

`default_nettype wire
